### rtl/ist_pkg.sv
// Shared types, codes and character classes for the identifier symbol table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ist_pkg;

  localparam int SUM_W   = 16;
  localparam int LEN_W   = 8;
  localparam int CHAR_W  = 8;
  localparam int MAXL_W  = 6;
  localparam int STAT_W  = 3;
  localparam int IDX_W   = 10;
  localparam int HASH_W  = 7;
  localparam logic [LEN_W-1:0]  LEN_SAT      = 8'd255;
  localparam logic [MAXL_W-1:0] MAXLEN_RESET = 6'd12;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_IDENT   = 2'd1,
    MODE_DIGIT   = 2'd2,
    MODE_ILLEGAL = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ENTERED  = 3'd0,
    ST_EXISTED  = 3'd1,
    ST_ILLEGAL  = 3'd2,
    ST_DIGIT    = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_OVERFLOW = 3'd5
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic char_accept;
    logic div_start;
    logic div_step;
    logic clear_step;
    logic term_write;
    logic head_read;
    logic e_load_head;
    logic e_load_link;
    logic ent_read;
    logic cmp_clear;
    logic cmp_read;
    logic cmp_next;
    logic insert;
    logic load_out;
    res_t res;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  finishes;
    logic  clear_last;
    logic  div_last;
    mode_t mode;
    logic  too_long;
    logic  no_room;
    logic  head_valid;
    logic  e_in_range;
    logic  byte_eq;
    logic  cmp_last;
    logic  link_valid;
    logic  table_full;
    logic  out_free;
  } sts_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_sep(input logic [CHAR_W-1:0] c);
    return c == 8'h2e || c == 8'h2c || c == 8'h3b || c == 8'h3a || c == 8'h3f ||
           c == 8'h21 || c == 8'h09 || c == 8'h0a || c == 8'h20;
  endfunction

endpackage

### rtl/ist_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
// Stands alone; used for every table of the symbol table.
`timescale 1ns / 1ps

module ist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  output logic [WIDTH-1:0]                    rdata_a,
  input  logic                                re_b,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                    rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/ist_ctrl.sv
// Controller of the symbol table: sequences clearing, hashing, chain walk,
// compare, insert and result hand-over. Uses ist_pkg command/status types.
`timescale 1ns / 1ps

module ist_ctrl import ist_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_CHECK, S_HEAD, S_ENT_RD, S_ENT_WAIT,
    S_CMP_RD, S_CMP_CHK, S_NOTFOUND, S_DONE
  } state_t;

  state_t state, state_next;
  res_t   res, res_next;

  // Hold state and the result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      res   <= ST_ENTERED;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.res    = res;
    state_next = state;
    res_next   = res;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.char_accept = in_valid;
        if (in_valid && sts.finishes) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.mode == MODE_ILLEGAL) begin
          res_next   = ST_ILLEGAL;
          state_next = S_DONE;
        end else if (sts.mode == MODE_DIGIT) begin
          res_next   = ST_DIGIT;
          state_next = S_DONE;
        end else if (sts.too_long) begin
          res_next   = ST_TOO_LONG;
          state_next = S_DONE;
        end else if (sts.no_room) begin
          res_next   = ST_OVERFLOW;
          state_next = S_DONE;
        end else begin
          cmd.term_write = 1'b1;
          cmd.head_read  = 1'b1;
          state_next     = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts.head_valid) begin
          cmd.e_load_head = 1'b1;
          state_next      = S_ENT_RD;
        end else begin
          state_next = S_NOTFOUND;
        end
      end
      S_ENT_RD: begin
        if (sts.e_in_range) begin
          cmd.ent_read  = 1'b1;
          cmd.cmp_clear = 1'b1;
          state_next    = S_ENT_WAIT;
        end else begin
          state_next = S_NOTFOUND;
        end
      end
      S_ENT_WAIT: begin
        state_next = S_CMP_RD;
      end
      S_CMP_RD: begin
        cmd.cmp_read = 1'b1;
        state_next   = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        priority if (sts.byte_eq && sts.cmp_last) begin
          res_next   = ST_EXISTED;
          state_next = S_DONE;
        end else if (sts.byte_eq) begin
          cmd.cmp_next = 1'b1;
          state_next   = S_CMP_RD;
        end else if (sts.link_valid) begin
          cmd.e_load_link = 1'b1;
          state_next      = S_ENT_RD;
        end else begin
          state_next = S_NOTFOUND;
        end
      end
      S_NOTFOUND: begin
        if (sts.table_full) begin
          res_next = ST_OVERFLOW;
        end else begin
          cmd.insert = 1'b1;
          res_next   = ST_ENTERED;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/ist_dp.sv
// Datapath of the symbol table: scan state, byte-sum remainder unit, string,
// bucket and entry memories, compare and output register. Uses ist_pkg, ist_ram.
`timescale 1ns / 1ps

module ist_dp import ist_pkg::*; #(
  parameter int STRING_BYTES = 1024,
  parameter int BUCKETS      = 128,
  parameter int MAX_ENTRIES  = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               end_of_stream,
  input  logic               cfg_write,
  input  logic [MAXL_W-1:0]  cfg_data,
  input  cmd_t               cmd,
  output sts_t               sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [IDX_W-1:0]   string_index,
  output logic [HASH_W-1:0]  hash_code,
  output logic [LEN_W-1:0]   id_length
);

  localparam int SW = $clog2(STRING_BYTES);
  localparam int HW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = $clog2(MAX_ENTRIES);
  localparam int CW = EW + 1;
  localparam int PW = SW + 9;
  // Reciprocal of the bucket count, exact for every 16-bit sum
  localparam int DIV_SH = SUM_W + ((BUCKETS > 1) ? $clog2(BUCKETS) : 0);
  localparam int MW = 18;
  localparam longint DIV_MUL = (longint'(1) << DIV_SH) / BUCKETS + 1;

  mode_t             scan_mode;
  logic [SW:0]       tok_start;
  logic [LEN_W-1:0]  tok_len;
  logic [SUM_W-1:0]  byte_sum;
  logic [SW:0]       fill;
  logic [CW-1:0]     count;
  logic [MAXL_W-1:0] max_len;
  logic [HW-1:0]     rem;
  logic              div_phase;
  logic [SUM_W-1:0]  quot;
  logic [HW-1:0]     clr_addr;
  logic [EW-1:0]     e_idx;
  logic [LEN_W-1:0]  k;

  logic [HW-1:0]     hash;
  logic [SUM_W+MW-1:0] prod;
  logic [HW-1:0]     rem_next;
  logic [PW-1:0]     pos;
  logic              is_l, is_d, is_s, ends_tok;
  logic              store_we;
  logic [SW-1:0]     store_waddr;
  logic [7:0]        store_wdata;
  logic [7:0]        store_a, store_b;
  logic [EW:0]       bucket_rd;
  logic [SW-1:0]     start_rd;
  logic [EW:0]       link_rd;

  assign is_l     = is_letter(char_code);
  assign is_d     = is_digit(char_code);
  assign is_s     = is_sep(char_code);
  assign ends_tok = end_of_stream || is_s;
  assign hash     = rem;
  assign pos      = PW'(tok_start) + PW'(tok_len);

  // Remainder: quotient by reciprocal multiply, then take back quotient times buckets
  assign prod     = (SUM_W + MW)'(byte_sum) * (SUM_W + MW)'(DIV_MUL);
  assign rem_next = HW'(byte_sum - SUM_W'(quot * BUCKETS));

  // String store write: identifier bytes while scanning, terminator at finish
  always_comb begin
    store_we    = 1'b0;
    store_waddr = SW'(pos);
    store_wdata = char_code;
    if (cmd.term_write) begin
      store_we    = 1'b1;
      store_wdata = 8'd0;
    end else if (cmd.char_accept && !ends_tok) begin
      if (scan_mode == MODE_IDLE) begin
        store_waddr = SW'(fill);
        store_we    = is_l && (PW'(fill) < PW'(STRING_BYTES));
      end else begin
        store_we = (scan_mode == MODE_IDENT) && (is_l || is_d) && (tok_len != LEN_SAT) &&
                   (pos < PW'(STRING_BYTES));
      end
    end
  end

  // Scan state, counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_IDLE;
      tok_start <= '0;
      tok_len   <= '0;
      byte_sum  <= '0;
      fill      <= '0;
      count     <= '0;
      max_len   <= MAXLEN_RESET;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      // Open or extend a token
      if (cmd.char_accept && !ends_tok) begin
        if (scan_mode == MODE_IDLE) begin
          scan_mode <= is_l ? MODE_IDENT : (is_d ? MODE_DIGIT : MODE_ILLEGAL);
          tok_start <= fill;
          tok_len   <= LEN_W'(1);
          byte_sum  <= SUM_W'(char_code);
        end else begin
          if (!is_l && !is_d) begin
            scan_mode <= MODE_ILLEGAL;
          end
          if (tok_len != LEN_SAT) begin
            tok_len <= tok_len + 1'b1;
          end
          byte_sum <= byte_sum + SUM_W'(char_code);
        end
      end
      // Link a new entry in
      if (cmd.insert) begin
        count <= count + 1'b1;
        fill  <= (SW + 1)'(pos + PW'(1));
      end
      // Hand over the result
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        scan_mode <= MODE_IDLE;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Remainder unit, chain cursor, compare offset and result payload
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_phase <= 1'b0;
    end else if (cmd.div_step) begin
      div_phase <= 1'b1;
      if (!div_phase) begin
        quot <= SUM_W'(prod >> DIV_SH);
      end else begin
        rem <= rem_next;
      end
    end
    if (cmd.e_load_head) begin
      e_idx <= bucket_rd[EW-1:0];
    end else if (cmd.e_load_link) begin
      e_idx <= link_rd[EW-1:0];
    end
    if (cmd.cmp_clear) begin
      k <= '0;
    end else if (cmd.cmp_next) begin
      k <= k + 1'b1;
    end
    if (cmd.load_out) begin
      status       <= cmd.res;
      string_index <= (cmd.res == ST_EXISTED) ? IDX_W'(start_rd) : IDX_W'(tok_start);
      hash_code    <= HASH_W'(hash);
      id_length    <= tok_len;
    end
  end

  ist_ram #(.WIDTH(8), .DEPTH(STRING_BYTES)) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (store_waddr),
    .wdata   (store_wdata),
    .re_a    (cmd.cmp_read),
    .raddr_a (SW'(PW'(start_rd) + PW'(k))),
    .rdata_a (store_a),
    .re_b    (cmd.cmp_read),
    .raddr_b (SW'(pos - PW'(tok_len) + PW'(k))),
    .rdata_b (store_b)
  );

  // Bucket heads carry a valid bit; cleared by a sweep after reset
  ist_ram #(.WIDTH(EW + 1), .DEPTH(BUCKETS)) u_bucket (
    .clk     (clk),
    .we      (cmd.clear_step || cmd.insert),
    .waddr   (cmd.clear_step ? clr_addr : hash),
    .wdata   (cmd.clear_step ? '0 : {1'b1, count[EW-1:0]}),
    .re_a    (cmd.head_read),
    .raddr_a (hash),
    .rdata_a (bucket_rd),
    .re_b    (1'b0),
    .raddr_b (hash),
    .rdata_b ()
  );

  ist_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_start (
    .clk     (clk),
    .we      (cmd.insert),
    .waddr   (count[EW-1:0]),
    .wdata   (tok_start[SW-1:0]),
    .re_a    (cmd.ent_read),
    .raddr_a (e_idx),
    .rdata_a (start_rd),
    .re_b    (1'b0),
    .raddr_b (e_idx),
    .rdata_b ()
  );

  // Link word: valid bit and next entry, taken from the old bucket head
  ist_ram #(.WIDTH(EW + 1), .DEPTH(MAX_ENTRIES)) u_link (
    .clk     (clk),
    .we      (cmd.insert),
    .waddr   (count[EW-1:0]),
    .wdata   (bucket_rd),
    .re_a    (cmd.ent_read),
    .raddr_a (e_idx),
    .rdata_a (link_rd),
    .re_b    (1'b0),
    .raddr_b (e_idx),
    .rdata_b ()
  );

  // Status towards the controller
  always_comb begin
    sts.finishes   = ends_tok && (scan_mode != MODE_IDLE);
    sts.clear_last = (clr_addr == HW'(BUCKETS - 1));
    sts.div_last   = div_phase;
    sts.mode       = scan_mode;
    sts.too_long   = tok_len > LEN_W'(max_len);
    sts.no_room    = (pos + PW'(1)) > PW'(STRING_BYTES);
    sts.head_valid = bucket_rd[EW];
    sts.e_in_range = CW'(e_idx) < count;
    sts.byte_eq    = (store_a == store_b);
    sts.cmp_last   = (k == tok_len);
    sts.link_valid = link_rd[EW];
    sts.table_full = count >= CW'(MAX_ENTRIES);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

### rtl/identifier_symbol_table.sv
// Identifier symbol table: a character is accepted in the cycle it is presented
// while in_stall is low; a separator or end of stream that closes a token holds
// the input through the remainder (quotient step, then remainder step), for a
// well-formed name the chain walk and the compare (a read and a check per byte)
// and the insert of a new name, and through any stall of the result.
// Synchronous reset; a sweep then clears the bucket heads with the input stalled.
`timescale 1ns / 1ps

module identifier_symbol_table import ist_pkg::*; #(
  parameter int STRING_BYTES = 1024,
  parameter int BUCKETS      = 128,
  parameter int MAX_ENTRIES  = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               end_of_stream,
  input  logic               cfg_write,
  input  logic [MAXL_W-1:0]  cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [IDX_W-1:0]   string_index,
  output logic [HASH_W-1:0]  hash_code,
  output logic [LEN_W-1:0]   id_length
);

  cmd_t cmd;
  sts_t sts;

  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ist_dp #(
    .STRING_BYTES (STRING_BYTES),
    .BUCKETS      (BUCKETS),
    .MAX_ENTRIES  (MAX_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .char_code     (char_code),
    .end_of_stream (end_of_stream),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .string_index  (string_index),
    .hash_code     (hash_code),
    .id_length     (id_length)
  );

endmodule

### rtl/ist_checker.sv
// Port-level checks on the symbol table results, bound to the top level.
// Depends on ist_pkg for codes and widths.
`timescale 1ns / 1ps

module ist_checker import ist_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [LEN_W-1:0]  id_length
);

  // Only defined result codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_OVERFLOW))
    else $error("undefined result code");

  // Every reported token has at least one character
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (id_length != '0))
    else $error("result with empty token");

  // A kept or found identifier is never longer than the register allows
  a_len_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ENTERED || status == ST_EXISTED) |-> (id_length <= 8'd63))
    else $error("stored identifier too long");

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(id_length))
    else $error("stalled result changed");

endmodule

bind identifier_symbol_table ist_checker u_ist_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .id_length (id_length)
);
